@@ design/assert_macros.svh @@
// assertion helpers shared by the one-wire master modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, muted during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("one-wire master check failed");

// next-cycle implication, muted during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("one-wire master check failed");

`endif

@@ design/owm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// owm_pkg
// Shared widths, codes, register map and types of the one-wire master.
// ------------------------------------------------------------------------
package owm_pkg;

    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_IDX_W     = $clog2(BITS_PER_BYTE);
    localparam int BYTE_W        = 8;
    localparam int FUNC_W        = 2;
    localparam int TICK_W        = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    // command codes on the func field
    localparam logic [FUNC_W-1:0] FUNC_RESET = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_START    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_HOLD     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RECOVERY      = 3'd5;

    // register defaults in microsecond ticks
    localparam logic [TICK_W-1:0] DEF_RESET_LOW     = 10'd480;
    localparam logic [TICK_W-1:0] DEF_PRESENCE_WAIT = 10'd60;
    localparam logic [TICK_W-1:0] DEF_RESET_TAIL    = 10'd420;
    localparam logic [TICK_W-1:0] DEF_SLOT_START    = 10'd2;
    localparam logic [TICK_W-1:0] DEF_SLOT_HOLD     = 10'd60;
    localparam logic [TICK_W-1:0] DEF_RECOVERY      = 10'd2;

    // tick class decided by the front end
    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_RESET = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_READ  = 2'd3
    } kind_t;

    // one classified tick waiting for the engine
    typedef struct packed {
        kind_t               kind;
        logic [BYTE_W-1:0]   wr_data;
        logic                line_in;
    } tick_entry_t;

    // timing registers seen by the engine
    typedef struct packed {
        logic [TICK_W-1:0] reset_low;
        logic [TICK_W-1:0] presence_wait;
        logic [TICK_W-1:0] reset_tail;
        logic [TICK_W-1:0] slot_start;
        logic [TICK_W-1:0] slot_hold;
        logic [TICK_W-1:0] recovery;
    } owm_cfg_t;

endpackage
`default_nettype wire

@@ design/owm_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ------------------------------------------------------------------------
// owm_if
// Handshake channels of the one-wire master: ticks in, results out, config.
// ------------------------------------------------------------------------

// one bus tick request
interface owm_tick_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd_valid;
    logic [owm_pkg::FUNC_W-1:0]    func;
    logic [owm_pkg::BYTE_W-1:0]    wr_data;
    logic                          line_in;

    modport source (output valid, output cmd_valid, output func, output wr_data,
                    output line_in, input ready);
    modport sink   (input valid, input cmd_valid, input func, input wr_data,
                    input line_in, output ready);
endinterface

// one result per tick
interface owm_res_if;
    logic                          valid;
    logic                          ready;
    logic                          line_drive_low;
    logic                          busy_res;
    logic                          done_res;
    logic [owm_pkg::BYTE_W-1:0]    rd_data;
    logic                          presence;

    modport source (output valid, output line_drive_low, output busy_res,
                    output done_res, output rd_data, output presence, input ready);
    modport sink   (input valid, input line_drive_low, input busy_res,
                    input done_res, input rd_data, input presence, output ready);
endinterface

// register write channel
interface owm_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [owm_pkg::CFG_IDX_W-1:0]  index;
    logic [owm_pkg::TICK_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/owm_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// owm_front
// Accepts tick requests, classifies the command and queues them for the
// sequencing engine in a two-entry queue.
// ------------------------------------------------------------------------
module owm_front (
    input  logic                  clk,
    input  logic                  rst_n,
    owm_tick_if.sink              tick,
    output logic                  q_valid,
    input  logic                  q_ready,
    output owm_pkg::tick_entry_t  q_head
);
    import owm_pkg::*;

    tick_entry_t         q_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                push;
    logic                pop;
    tick_entry_t         entry;

    // classify the command carried by this tick
    always_comb
    begin
        entry.wr_data = tick.wr_data;
        entry.line_in = tick.line_in;
        entry.kind    = KIND_NONE;
        if (tick.cmd_valid)
        begin
            case (tick.func)
                FUNC_RESET: entry.kind = KIND_RESET;
                FUNC_WRITE: entry.kind = KIND_WRITE;
                FUNC_READ:  entry.kind = KIND_READ;
                default:    entry.kind = KIND_NONE;
            endcase
        end
    end

    // queue handshake
    assign tick.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign push       = tick.valid && tick.ready;
    assign q_valid    = (count_reg != '0);
    assign pop        = q_valid && q_ready;
    assign q_head     = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= entry;
        end
    end

    `ASSERT_IMPLIES(a_count_bound, clk, rst_n, 1'b1, count_reg <= QCNT_W'(QUEUE_DEPTH))
    `ASSERT_NEXT(a_push_grows, clk, rst_n, push && !pop, count_reg == $past(count_reg) + 2'd1)
    `ASSERT_NEXT(a_pop_shrinks, clk, rst_n, pop && !push, count_reg == $past(count_reg) - 2'd1)

endmodule
`default_nettype wire

@@ design/owm_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ------------------------------------------------------------------------
// owm_engine
// Steps the reset and bit-slot sequences one tick per queued request and
// holds each tick's result in an output register.
// ------------------------------------------------------------------------
module owm_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  owm_pkg::tick_entry_t  q_head,
    input  owm_pkg::owm_cfg_t     cfg_regs,
    owm_res_if.source             res
);
    import owm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_RST_LOW  = 3'd1,
        PH_RST_WAIT = 3'd2,
        PH_RST_TAIL = 3'd3,
        PH_SLOT_LO  = 3'd4,
        PH_SLOT_HLD = 3'd5,
        PH_RECOVER  = 3'd6
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [TICK_W-1:0]      timer_reg, timer_next;
    logic [BIT_IDX_W-1:0]   bit_idx_reg, bit_idx_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    kind_t                  op_reg, op_next;
    logic                   presence_reg, presence_next;
    logic [BYTE_W-1:0]      last_read_reg, last_read_next;
    logic                   res_valid_reg, res_valid_next;
    logic                   drive_reg, drive_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;

    logic                   fire;
    logic                   start;
    phase_t                 ph;
    logic [TICK_W-1:0]      t;
    logic [TICK_W-1:0]      dur_raw;
    logic [TICK_W-1:0]      dur;
    logic                   ends;

    assign q_ready = !res_valid_reg || res.ready;
    assign fire    = q_valid && q_ready;
    assign start   = (phase_reg == PH_IDLE) && (q_head.kind != KIND_NONE);
    assign ph      = start ? ((q_head.kind == KIND_RESET) ? PH_RST_LOW : PH_SLOT_LO)
                           : phase_reg;
    assign t       = start ? '0 : timer_reg;

    // duration of the current phase, zero counts as one tick
    always_comb
    begin
        case (ph)
            PH_RST_LOW:  dur_raw = cfg_regs.reset_low;
            PH_RST_WAIT: dur_raw = cfg_regs.presence_wait;
            PH_RST_TAIL: dur_raw = cfg_regs.reset_tail;
            PH_SLOT_LO:  dur_raw = cfg_regs.slot_start;
            PH_SLOT_HLD: dur_raw = cfg_regs.slot_hold;
            PH_RECOVER:  dur_raw = cfg_regs.recovery;
            default:     dur_raw = cfg_regs.slot_start;
        endcase
        dur  = (dur_raw == '0) ? TICK_W'(1) : dur_raw;
        ends = ({1'b0, t} + 1'b1) >= {1'b0, dur};
    end

    // one tick of the sequencer
    always_comb
    begin
        phase_next     = phase_reg;
        timer_next     = timer_reg;
        bit_idx_next   = bit_idx_reg;
        shift_next     = shift_reg;
        op_next        = op_reg;
        presence_next  = presence_reg;
        last_read_next = last_read_reg;
        drive_next     = drive_reg;
        busy_next      = busy_reg;
        done_next      = done_reg;
        res_valid_next = res.ready ? 1'b0 : res_valid_reg;

        if (fire)
        begin
            res_valid_next = 1'b1;
            drive_next     = 1'b0;
            done_next      = 1'b0;
            busy_next      = (ph != PH_IDLE);
            if (start)
            begin
                op_next      = q_head.kind;
                bit_idx_next = '0;
                shift_next   = (q_head.kind == KIND_WRITE) ? q_head.wr_data : '0;
            end
            if (ph != PH_IDLE)
            begin
                timer_next = ends ? '0 : t + 1'b1;
            end

            case (ph)
                PH_RST_LOW:
                begin
                    drive_next = 1'b1;
                    if (ends)
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    else
                    begin
                        phase_next = ph;
                    end
                end
                PH_RST_WAIT:
                begin
                    phase_next = ph;
                    if (ends)
                    begin
                        presence_next = !q_head.line_in;
                        phase_next    = PH_RST_TAIL;
                    end
                end
                PH_RST_TAIL:
                begin
                    phase_next = ph;
                    if (ends)
                    begin
                        phase_next = PH_IDLE;
                        done_next  = 1'b1;
                    end
                end
                PH_SLOT_LO:
                begin
                    drive_next = 1'b1;
                    phase_next = ends ? PH_SLOT_HLD : ph;
                end
                PH_SLOT_HLD:
                begin
                    phase_next = ph;
                    if (op_next == KIND_WRITE)
                    begin
                        drive_next = !shift_next[0];
                    end
                    else if (t == '0)
                    begin
                        shift_next = {q_head.line_in, shift_next[BYTE_W-1:1]};
                    end
                    if (ends)
                    begin
                        if (op_next == KIND_WRITE)
                        begin
                            shift_next = {1'b0, shift_next[BYTE_W-1:1]};
                        end
                        if (bit_idx_next == BIT_IDX_W'(BITS_PER_BYTE - 1))
                        begin
                            if (op_next == KIND_READ)
                            begin
                                last_read_next = shift_next;
                            end
                            bit_idx_next = '0;
                            phase_next   = PH_IDLE;
                            done_next    = 1'b1;
                        end
                        else
                        begin
                            phase_next = PH_RECOVER;
                        end
                    end
                end
                PH_RECOVER:
                begin
                    phase_next = ph;
                    if (ends)
                    begin
                        bit_idx_next = bit_idx_reg + 1'b1;
                        phase_next   = PH_SLOT_LO;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            op_reg        <= KIND_NONE;
            presence_reg  <= 1'b0;
            last_read_reg <= '0;
            res_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            timer_reg     <= timer_next;
            bit_idx_reg   <= bit_idx_next;
            shift_reg     <= shift_next;
            op_reg        <= op_next;
            presence_reg  <= presence_next;
            last_read_reg <= last_read_next;
            res_valid_reg <= res_valid_next;
            drive_reg     <= drive_next;
            busy_reg      <= busy_next;
            done_reg      <= done_next;
        end
    end

    assign res.valid          = res_valid_reg;
    assign res.line_drive_low = drive_reg;
    assign res.busy_res       = busy_reg;
    assign res.done_res       = done_reg;
    assign res.rd_data        = last_read_reg;
    assign res.presence       = presence_reg;

    `ASSERT_IMPLIES(a_done_busy, clk, rst_n, res_valid_reg && done_reg, busy_reg)
    `ASSERT_IMPLIES(a_idle_bit0, clk, rst_n, phase_reg == PH_IDLE, bit_idx_reg == '0)
    `ASSERT_IMPLIES(a_timer_range, clk, rst_n, 1'b1, timer_reg != '1)
    `ASSERT_NEXT(a_fire_result, clk, rst_n, fire, res_valid_reg)

endmodule
`default_nettype wire

@@ design/one_wire_bus_master.sv @@
`timescale 1ns / 1ps
`default_nettype none
// a tick's result is offered from the engine's result register once the tick has left the queue
// throughput: one tick per clock while the result is taken; the phase timer steps once per tick
// a two-entry queue decouples the tick input from the result register
// reset: asynchronous, active low; sequencer idle, result outputs zero, timing
// registers at their defaults; no clearing pass
// ------------------------------------------------------------------------
// one_wire_bus_master
// One-wire bus master: timing registers, tick front end and sequencing engine.
// ------------------------------------------------------------------------
module one_wire_bus_master (
    input  logic        clk,
    input  logic        rst_n,
    owm_tick_if.sink    tick,
    owm_res_if.source   res,
    owm_cfg_if.sink     cfg
);
    import owm_pkg::*;

    owm_cfg_t     cfg_reg;
    owm_cfg_t     cfg_next;
    logic         q_valid;
    logic         q_ready;
    tick_entry_t  q_head;

    assign cfg.ready = 1'b1;

    // register write decode, unknown indexes dropped
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                REG_RESET_LOW:     cfg_next.reset_low     = cfg.data;
                REG_PRESENCE_WAIT: cfg_next.presence_wait = cfg.data;
                REG_RESET_TAIL:    cfg_next.reset_tail    = cfg.data;
                REG_SLOT_START:    cfg_next.slot_start    = cfg.data;
                REG_SLOT_HOLD:     cfg_next.slot_hold     = cfg.data;
                REG_RECOVERY:      cfg_next.recovery      = cfg.data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    // timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low     <= DEF_RESET_LOW;
            cfg_reg.presence_wait <= DEF_PRESENCE_WAIT;
            cfg_reg.reset_tail    <= DEF_RESET_TAIL;
            cfg_reg.slot_start    <= DEF_SLOT_START;
            cfg_reg.slot_hold     <= DEF_SLOT_HOLD;
            cfg_reg.recovery      <= DEF_RECOVERY;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // tick intake and classification
    owm_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick    (tick),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_head  (q_head)
    );

    // bus sequencing
    owm_engine u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_head   (q_head),
        .cfg_regs (cfg_reg),
        .res      (res)
    );

endmodule
`default_nettype wire
